/* rtl/spmf_pkg.sv */
// spmf_pkg: shared codes for the strict priority multi fifo unit
`default_nettype none

package spmf_pkg;

	// operation carried by an input transaction
	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_ENQ    = 3'd0,
		ST_DEQ    = 3'd1,
		ST_FULL   = 3'd2,
		ST_EMPTY  = 3'd3,
		ST_BADLVL = 3'd4
	} status_t;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned REQ_LEVEL_W = 2;
	localparam int unsigned STATUS_W    = 3;

endpackage

`default_nettype wire

/* rtl/spmf_ram.sv */
// spmf_ram: generic simple dual port ram with registered read
`default_nettype none

module spmf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 24
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

/* rtl/strict_priority_multi_fifo_unit.sv */
// strict_priority_multi_fifo_unit: strict priority queue with one ring fifo per level
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid / in_stall   | mode, req_level, in_value
//  out     | output    | out_valid / out_stall | status, out_value, out_level
//
// One transaction per cycle is accepted while in_stall is low; each gives one result.
// The single slot ram (one write, one registered read port) sets the latency:
// a dequeue reads its value in the accept cycle and the data lands in the next cycle.
// Head pointers and occupancy counts sit in flops and are updated at accept.
// Reset clears pointers, counts and valid flags at once; slot contents are not cleared.
// A stalled output holds its result; the read stage keeps one more, then in_stall rises.
`default_nettype none

module strict_priority_multi_fifo_unit
	import spmf_pkg::*;
#(
	parameter int unsigned LEVELS = 3,
	parameter int unsigned DEPTH  = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         mode,
	input  wire logic [REQ_LEVEL_W-1:0]       req_level,
	input  wire logic signed [VALUE_W-1:0]    in_value,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic      [STATUS_W-1:0]          status,
	output logic signed [VALUE_W-1:0]         out_value,
	output logic      [REQ_LEVEL_W-1:0]       out_level
);

	localparam int unsigned LVL_W  = $clog2(LEVELS);
	localparam int unsigned PTR_W  = $clog2(DEPTH);
	localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
	localparam int unsigned SLOTS  = LEVELS * DEPTH;
	localparam int unsigned ADDR_W = $clog2(SLOTS);
	localparam int unsigned TOT_W  = $clog2(SLOTS + 1);

	localparam logic [3:0]        LEVELS_4 = 4'(LEVELS);
	localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(DEPTH);
	localparam logic [PTR_W:0]    DEPTH_P  = (PTR_W + 1)'(DEPTH);
	localparam logic [PTR_W-1:0]  LAST_P   = PTR_W'(DEPTH - 1);
	localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(DEPTH);

	// per level ring state
	logic [PTR_W-1:0] head_q [LEVELS];
	logic [CNT_W-1:0] occ_q  [LEVELS];

	// read stage and output register
	logic                   v1_q;
	status_t                status_s1;
	logic [REQ_LEVEL_W-1:0] level_s1;
	logic                   vo_q;
	status_t                status_q;
	logic [REQ_LEVEL_W-1:0] level_q;
	logic [VALUE_W-1:0]     value_q;

	logic                   in_accept;
	logic                   advance;
	logic                   lvl_ok;
	logic [LVL_W-1:0]       req_idx;
	logic [LEVELS-1:0]      nonempty;
	logic [LVL_W-1:0]       pick;
	logic [LVL_W-1:0]       sel_lvl;
	logic [PTR_W-1:0]       head_sel;
	logic [CNT_W-1:0]       occ_sel;
	logic                   sel_full;
	logic [PTR_W:0]         tail_sum;
	logic [PTR_W-1:0]       tail;
	logic [PTR_W-1:0]       head_next;
	logic [ADDR_W-1:0]      base_addr;
	logic                   do_enq;
	logic                   do_deq;
	status_t                status_d;
	logic [REQ_LEVEL_W-1:0] level_d;
	logic [VALUE_W-1:0]     rd_data;

	// handshake: output register frees, read stage moves up, input refills
	assign advance   = v1_q && (!vo_q || !out_stall);
	assign in_stall  = v1_q && !advance;
	assign in_accept = in_valid && !in_stall;

	// enqueue level check and index
	assign lvl_ok  = ({2'b00, req_level} < LEVELS_4);
	assign req_idx = LVL_W'(req_level);

	// highest priority non-empty level
	always_comb begin
		pick = '0;
		for (int i = LEVELS - 1; i >= 0; i--) begin
			nonempty[i] = (occ_q[i] != '0);
			if (nonempty[i]) begin
				pick = LVL_W'(i);
			end
		end
	end

	// selected level state
	always_comb begin
		if (mode == MODE_DEQ) begin
			sel_lvl = pick;
		end else if (lvl_ok) begin
			sel_lvl = req_idx;
		end else begin
			sel_lvl = '0;
		end
	end

	assign head_sel  = head_q[sel_lvl];
	assign occ_sel   = occ_q[sel_lvl];
	assign sel_full  = (occ_sel == DEPTH_C);

	// ring arithmetic: tail wraps once at most, head steps by one
	assign tail_sum  = (PTR_W + 1)'(head_sel) + (PTR_W + 1)'(occ_sel);
	assign tail      = (tail_sum >= DEPTH_P) ? PTR_W'(tail_sum - DEPTH_P)
	                                         : PTR_W'(tail_sum);
	assign head_next = (head_sel == LAST_P) ? '0 : head_sel + 1'b1;
	assign base_addr = ADDR_W'(sel_lvl) * DEPTH_A;

	// decode of the transaction
	always_comb begin
		do_enq   = 1'b0;
		do_deq   = 1'b0;
		status_d = ST_EMPTY;
		level_d  = '0;
		if (mode == MODE_ENQ) begin
			if (!lvl_ok) begin
				status_d = ST_BADLVL;
			end else if (sel_full) begin
				status_d = ST_FULL;
				level_d  = req_level;
			end else begin
				status_d = ST_ENQ;
				level_d  = req_level;
				do_enq   = in_accept;
			end
		end else if (|nonempty) begin
			status_d = ST_DEQ;
			level_d  = REQ_LEVEL_W'(pick);
			do_deq   = in_accept;
		end
	end

	// slot memory
	spmf_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (do_enq),
		.wr_addr (base_addr + ADDR_W'(tail)),
		.wr_data (in_value),
		.rd_en   (do_deq),
		.rd_addr (base_addr + ADDR_W'(head_sel)),
		.rd_data (rd_data)
	);

	// head pointers and occupancy update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEVELS; i++) begin
				head_q[i] <= '0;
				occ_q[i]  <= '0;
			end
		end else if (do_enq) begin
			occ_q[sel_lvl] <= occ_sel + 1'b1;
		end else if (do_deq) begin
			occ_q[sel_lvl]  <= occ_sel - 1'b1;
			head_q[sel_lvl] <= head_next;
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
		end else if (in_accept) begin
			v1_q <= 1'b1;
		end else if (advance) begin
			v1_q <= 1'b0;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			status_s1 <= status_d;
			level_s1  <= level_d;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (advance) begin
			vo_q <= 1'b1;
		end else if (!out_stall) begin
			vo_q <= 1'b0;
		end
	end

	// output register payload, value only for a dequeue
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_s1;
			level_q  <= level_s1;
			value_q  <= (status_s1 == ST_DEQ) ? rd_data : '0;
		end
	end

	assign out_valid = vo_q;
	assign status    = status_q;
	assign out_level = level_q;
	assign out_value = value_q;

	// total held entries and capacity check
	logic [TOT_W-1:0] occ_total;
	logic             over_cap;

	always_comb begin
		occ_total = '0;
		over_cap  = 1'b0;
		for (int i = 0; i < LEVELS; i++) begin
			occ_total = occ_total + TOT_W'(occ_q[i]);
			if (occ_q[i] > DEPTH_C) begin
				over_cap = 1'b1;
			end
		end
	end

	// no level ever holds more than its ring
	a_cap: assert property (@(posedge clk) disable iff (!arst_n) !over_cap)
		else $error("level occupancy above depth");

	// a stored enqueue adds exactly one entry
	a_enq: assert property (@(posedge clk) disable iff (!arst_n)
		do_enq |=> (occ_total == $past(occ_total) + 1'b1))
		else $error("enqueue did not add one entry");

	// a dequeue removes exactly one entry
	a_deq: assert property (@(posedge clk) disable iff (!arst_n)
		do_deq |=> (occ_total == $past(occ_total) - 1'b1))
		else $error("dequeue did not remove one entry");

	// refused or absent transactions leave the fill unchanged
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!do_enq && !do_deq) |=> $stable(occ_total))
		else $error("fill changed without a transaction");

endmodule

`default_nettype wire
